FILE: hw/rtl/mcfm_pkg.sv
// Shared types, constants and helpers of the mic/clip frame mixer.
package mcfm_pkg;

    // Fixed field widths
    localparam int GAIN_BITS    = 16;
    localparam int BAL_BITS     = 17;
    localparam int ACC_BITS     = 32;
    // Multiplicand width of the serial multiplier (accumulator magnitude)
    localparam int MUL_A_BITS   = 32;
    // Magnitude of a master-gained output sample
    localparam int OUT_MAG_BITS = 35;
    localparam int MIC_PK_BITS  = 20;
    localparam int MST_PK_BITS  = 24;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [BAL_BITS-1:0]    BAL_ONE       = 17'h10000;
    localparam logic [MIC_PK_BITS-1:0] MIC_PEAK_MAX  = 20'hFFFFF;
    localparam logic [MST_PK_BITS-1:0] MST_PEAK_MAX  = 24'hFFFFFF;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIC_GAIN    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MASTER_GAIN = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BALANCE     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIC_EN      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PASS_EN     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CAP_CH      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLAY_CH     = 3'd6;

    // Channel count codes
    localparam logic [1:0] CH_ZERO = 2'd0;
    localparam logic [1:0] CH_ONE  = 2'd1;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_MIC       = 2'd0,
        KIND_CLIP      = 2'd1,
        KIND_FRAME_END = 2'd2,
        KIND_PEAK_CLR  = 2'd3
    } t_kind;

    // Rounding shift applied by the multiplier
    typedef enum logic [2:0] {
        RND_NONE = 3'd0,
        RND_12   = 3'd1,
        RND_16   = 3'd2,
        RND_28   = 3'd3,
        RND_29   = 3'd4
    } t_rnd;

    typedef struct packed {
        logic start;
        t_rnd rnd;
    } t_mul_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MIC_GAIN,
        ST_MIC_MIX,
        ST_CLIP_G,
        ST_CLIP_L,
        ST_CLIP_R,
        ST_CLIP_M,
        ST_FE_L,
        ST_FE_R,
        ST_FE_OUT
    } t_state;

    // Accumulator plus a signed magnitude, saturated to 32 bits
    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0] acc,
        input logic [ACC_BITS-1:0]        mag,
        input logic                       neg
    );
        logic signed [ACC_BITS+1:0] d;
        logic signed [ACC_BITS+1:0] s;
        d = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        s = {{2{acc[ACC_BITS-1]}}, acc} + d;
        if (s > 34'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (s < -34'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return s[ACC_BITS-1:0];
    endfunction

endpackage

FILE: hw/rtl/mcfm_serial_mul.sv
// Bit-serial magnitude multiplier with round-to-nearest preload and shift.
module mcfm_serial_mul #(
    parameter int B_BITS = 17
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  mcfm_pkg::t_mul_cmd                         i_cmd,
    input  logic [mcfm_pkg::MUL_A_BITS-1:0]            i_a,
    input  logic [B_BITS-1:0]                          i_b,
    output logic                                       o_done,
    output logic [mcfm_pkg::MUL_A_BITS+B_BITS+1:0]     o_prod
);

    localparam int AW = mcfm_pkg::MUL_A_BITS;
    localparam int HW = AW + 2;
    localparam int PW = AW + B_BITS + 2;
    localparam int CW = $clog2(B_BITS + 1);

    logic [PW-1:0]     r_p;
    logic [AW-1:0]     r_a;
    logic [B_BITS-1:0] r_b;
    logic [CW-1:0]     r_cnt;
    logic              r_run;
    logic              r_done;
    mcfm_pkg::t_rnd    r_rnd;

    logic [PW-1:0]     preload;
    logic [HW-1:0]     hi_sum;

    // Half an LSB of the final shift, placed so that it lands there after the last step
    always_comb begin
        unique case (i_cmd.rnd)
            mcfm_pkg::RND_NONE: preload = '0;
            mcfm_pkg::RND_12:   preload = PW'(1) << (11 + B_BITS);
            mcfm_pkg::RND_16:   preload = PW'(1) << (15 + B_BITS);
            mcfm_pkg::RND_28:   preload = PW'(1) << (27 + B_BITS);
            mcfm_pkg::RND_29:   preload = PW'(1) << (28 + B_BITS);
            default:            preload = '0;
        endcase
    end

    // One multiplier bit per cycle: add the multiplicand on top, shift right
    assign hi_sum = r_p[PW-1:B_BITS] + (r_b[0] ? HW'(r_a) : HW'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(B_BITS);
            end else if (r_run) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_p   <= preload;
            r_a   <= i_a;
            r_b   <= i_b;
            r_rnd <= i_cmd.rnd;
        end else if (r_run) begin
            r_p <= {hi_sum, r_p[B_BITS-1:0]} >> 1;
            r_b <= r_b >> 1;
        end
    end

    // Final scaling
    always_comb begin
        unique case (r_rnd)
            mcfm_pkg::RND_NONE: o_prod = r_p;
            mcfm_pkg::RND_12:   o_prod = r_p >> 12;
            mcfm_pkg::RND_16:   o_prod = r_p >> 16;
            mcfm_pkg::RND_28:   o_prod = r_p >> 28;
            mcfm_pkg::RND_29:   o_prod = r_p >> 29;
            default:            o_prod = r_p;
        endcase
    end

    assign o_done = r_done;

endmodule

FILE: hw/rtl/mic_clip_frame_mixer_unit.sv
// Top level of the mic/clip frame mixer: config, sequencer, accumulators and output word.
// Every product runs through one shared bit-serial multiplier, one multiplier bit per
// cycle over B = max(17, SAMPLE_BITS+1) multiplier bits. An item is accepted, then
// decoded; then a mic word takes one multiply (two with passthrough, none when the mic
// is disabled or has no capture channel), a clip word three (stereo) or two (mono
// playback), a frame-end word two plus the output load, and a peak reset none. A
// finished frame waits in the output register while the next words are taken; only a
// second frame end stalls behind an output that has not been taken yet.
module mic_clip_frame_mixer_unit #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_wr_en,
    input  logic [mcfm_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [mcfm_pkg::BAL_BITS-1:0]         i_cfg_data,
    // input words
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_req_type,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_left,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_right,
    input  logic [mcfm_pkg::GAIN_BITS-1:0]        i_clip_gain,
    // output words
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]         o_out_left,
    output logic signed [SAMPLE_BITS-1:0]         o_out_right,
    output logic [mcfm_pkg::MIC_PK_BITS-1:0]      o_mic_peak,
    output logic [mcfm_pkg::MST_PK_BITS-1:0]      o_master_peak
);

    localparam int SB = SAMPLE_BITS;
    localparam int MB = (SAMPLE_BITS + 1 > 17) ? SAMPLE_BITS + 1 : 17;
    localparam int AW = mcfm_pkg::MUL_A_BITS;
    localparam int PW = AW + MB + 2;
    localparam int GB = mcfm_pkg::GAIN_BITS;
    localparam int BB = mcfm_pkg::BAL_BITS;
    localparam int ACW = mcfm_pkg::ACC_BITS;
    localparam int OM = mcfm_pkg::OUT_MAG_BITS;
    localparam logic [SB-1:0] LIM_POS = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] LIM_NEG = {1'b1, {(SB-1){1'b0}}};

    // Configuration registers
    logic [GB-1:0] r_mic_gain;
    logic [GB-1:0] r_master_gain;
    logic [BB-1:0] r_balance;
    logic          r_mic_en;
    logic          r_pass_en;
    logic [1:0]    r_cap_ch;
    logic [1:0]    r_play_ch;

    // Sequencer and word registers
    mcfm_pkg::t_state r_state;
    mcfm_pkg::t_state n_state;
    mcfm_pkg::t_kind  r_kind;
    logic signed [SB-1:0] r_l;
    logic signed [SB-1:0] r_r;
    logic [GB-1:0]        r_cg;
    logic                 r_sign;
    logic                 n_sign;
    logic [AW-1:0]        r_g;

    // Frame state
    logic signed [ACW-1:0]              r_acc_l;
    logic signed [ACW-1:0]              r_acc_r;
    logic [mcfm_pkg::MIC_PK_BITS-1:0]   r_mic_peak;
    logic [mcfm_pkg::MST_PK_BITS-1:0]   r_master_peak;
    logic [OM-1:0]                      r_ol_mag;
    logic                               r_ol_neg;
    logic [OM-1:0]                      r_or_mag;
    logic                               r_or_neg;

    // Output word
    logic                               r_out_valid;
    logic signed [SB-1:0]               r_out_l;
    logic signed [SB-1:0]               r_out_r;
    logic [mcfm_pkg::MIC_PK_BITS-1:0]   r_out_mpk;
    logic [mcfm_pkg::MST_PK_BITS-1:0]   r_out_spk;

    // Multiplier interface
    mcfm_pkg::t_mul_cmd mul_cmd;
    logic [AW-1:0]      mul_a;
    logic [MB-1:0]      mul_b;
    logic               mul_done;
    logic [PW-1:0]      prod;
    logic [AW-1:0]      prod_lo;

    // Derived operands
    logic [BB-1:0]        b_eff;
    logic [BB:0]          mf_full;
    logic [BB:0]          cf_full;
    logic [BB-1:0]        mic_fac;
    logic [BB-1:0]        clip_fac;
    logic signed [SB:0]   sum_lr;
    logic signed [SB-1:0] mono;
    logic [SB-1:0]        mono_mag;
    logic [SB:0]          sum_mag;
    logic [SB-1:0]        l_mag;
    logic [SB-1:0]        r_mag;
    logic [ACW-1:0]       acc_l_mag;
    logic [ACW-1:0]       acc_r_mag;
    logic                 play_mono;
    logic                 mic_go;
    logic                 out_free;
    logic [mcfm_pkg::MIC_PK_BITS-1:0] mic_a;
    logic [OM-1:0]                    pk_max;
    logic [mcfm_pkg::MST_PK_BITS-1:0] pk_sat;
    logic [mcfm_pkg::MST_PK_BITS-1:0] pk_new;
    logic signed [ACW-1:0]            acc_l_add;
    logic signed [ACW-1:0]            acc_r_add;

    // Output limiter on a signed magnitude
    function automatic logic [SB-1:0] limit(input logic [OM-1:0] mag, input logic neg);
        logic [SB-1:0] cm;
        if (neg) begin
            cm = (mag > OM'(LIM_NEG)) ? LIM_NEG : mag[SB-1:0];
            return ~cm + SB'(1);
        end
        cm = (mag > OM'(LIM_POS)) ? LIM_POS : mag[SB-1:0];
        return cm;
    endfunction

    mcfm_serial_mul #(
        .B_BITS (MB)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mul_cmd),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    assign prod_lo = prod[AW-1:0];

    // Balance factors: mic min(1, 2(1-b)), clip min(1, 2b)
    assign b_eff    = (r_balance > mcfm_pkg::BAL_ONE) ? mcfm_pkg::BAL_ONE : r_balance;
    assign mf_full  = {mcfm_pkg::BAL_ONE - b_eff, 1'b0};
    assign cf_full  = {b_eff, 1'b0};
    assign mic_fac  = (mf_full > (BB+1)'(mcfm_pkg::BAL_ONE)) ? mcfm_pkg::BAL_ONE
                                                              : mf_full[BB-1:0];
    assign clip_fac = (cf_full > (BB+1)'(mcfm_pkg::BAL_ONE)) ? mcfm_pkg::BAL_ONE
                                                              : cf_full[BB-1:0];

    // Sample magnitudes; the two-channel downmix is floor((L+R)/2)
    assign sum_lr    = {r_l[SB-1], r_l} + {r_r[SB-1], r_r};
    assign mono      = (r_cap_ch == mcfm_pkg::CH_ONE) ? r_l : sum_lr[SB:1];
    assign mono_mag  = mono[SB-1] ? SB'(-mono) : SB'(mono);
    assign sum_mag   = sum_lr[SB] ? (SB+1)'(-sum_lr) : (SB+1)'(sum_lr);
    assign l_mag     = r_l[SB-1] ? SB'(-r_l) : SB'(r_l);
    assign r_mag     = r_r[SB-1] ? SB'(-r_r) : SB'(r_r);
    assign acc_l_mag = r_acc_l[ACW-1] ? ACW'(-r_acc_l) : ACW'(r_acc_l);
    assign acc_r_mag = r_acc_r[ACW-1] ? ACW'(-r_acc_r) : ACW'(r_acc_r);

    assign play_mono = (r_play_ch == mcfm_pkg::CH_ONE);
    assign mic_go    = r_mic_en && (r_cap_ch != mcfm_pkg::CH_ZERO);
    assign out_free  = !r_out_valid || i_out_ready;

    assign acc_l_add = mcfm_pkg::sat_add(r_acc_l, prod_lo, r_sign);
    assign acc_r_add = mcfm_pkg::sat_add(r_acc_r, prod_lo, r_sign);

    // Peak of the gained mic mono, saturated
    assign mic_a = (prod_lo > AW'(mcfm_pkg::MIC_PEAK_MAX)) ? mcfm_pkg::MIC_PEAK_MAX
                                                           : prod_lo[mcfm_pkg::MIC_PK_BITS-1:0];

    // Master peak of the pre-limit frame
    assign pk_max = (r_or_mag > r_ol_mag) ? r_or_mag : r_ol_mag;
    assign pk_sat = (pk_max > OM'(mcfm_pkg::MST_PEAK_MAX)) ? mcfm_pkg::MST_PEAK_MAX
                                                           : pk_max[mcfm_pkg::MST_PK_BITS-1:0];
    assign pk_new = (pk_sat > r_master_peak) ? pk_sat : r_master_peak;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mic_gain    <= 16'd4096;
            r_master_gain <= 16'd4096;
            r_balance     <= 17'd32768;
            r_mic_en      <= 1'b1;
            r_pass_en     <= 1'b0;
            r_cap_ch      <= 2'd2;
            r_play_ch     <= 2'd2;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mcfm_pkg::CFG_MIC_GAIN:    r_mic_gain    <= i_cfg_data[GB-1:0];
                mcfm_pkg::CFG_MASTER_GAIN: r_master_gain <= i_cfg_data[GB-1:0];
                mcfm_pkg::CFG_BALANCE:     r_balance     <= i_cfg_data;
                mcfm_pkg::CFG_MIC_EN:      r_mic_en      <= i_cfg_data[0];
                mcfm_pkg::CFG_PASS_EN:     r_pass_en     <= i_cfg_data[0];
                mcfm_pkg::CFG_CAP_CH:      r_cap_ch      <= i_cfg_data[1:0];
                mcfm_pkg::CFG_PLAY_CH:     r_play_ch     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcfm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and multiplier issue
    always_comb begin
        n_state = r_state;
        n_sign  = r_sign;
        mul_cmd = '{start: 1'b0, rnd: mcfm_pkg::RND_NONE};
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            mcfm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = mcfm_pkg::ST_DECODE;
                end
            end
            mcfm_pkg::ST_DECODE: begin
                unique case (r_kind)
                    mcfm_pkg::KIND_MIC: begin
                        if (mic_go) begin
                            mul_cmd = '{start: 1'b1, rnd: mcfm_pkg::RND_12};
                            mul_a   = AW'(mono_mag);
                            mul_b   = MB'(r_mic_gain);
                            n_sign  = mono[SB-1];
                            n_state = mcfm_pkg::ST_MIC_GAIN;
                        end else begin
                            n_state = mcfm_pkg::ST_IDLE;
                        end
                    end
                    mcfm_pkg::KIND_CLIP: begin
                        mul_cmd = '{start: 1'b1, rnd: mcfm_pkg::RND_NONE};
                        mul_a   = AW'(r_cg);
                        mul_b   = MB'(clip_fac);
                        n_state = mcfm_pkg::ST_CLIP_G;
                    end
                    mcfm_pkg::KIND_FRAME_END: begin
                        mul_cmd = '{start: 1'b1, rnd: mcfm_pkg::RND_12};
                        mul_a   = acc_l_mag;
                        mul_b   = MB'(r_master_gain);
                        n_sign  = r_acc_l[ACW-1];
                        n_state = mcfm_pkg::ST_FE_L;
                    end
                    mcfm_pkg::KIND_PEAK_CLR: begin
                        n_state = mcfm_pkg::ST_IDLE;
                    end
                endcase
            end
            mcfm_pkg::ST_MIC_GAIN: begin
                if (mul_done) begin
                    if (r_pass_en) begin
                        mul_cmd = '{start: 1'b1, rnd: mcfm_pkg::RND_16};
                        mul_a   = prod_lo;
                        mul_b   = MB'(mic_fac);
                        n_state = mcfm_pkg::ST_MIC_MIX;
                    end else begin
                        n_state = mcfm_pkg::ST_IDLE;
                    end
                end
            end
            mcfm_pkg::ST_MIC_MIX: begin
                if (mul_done) begin
                    n_state = mcfm_pkg::ST_IDLE;
                end
            end
            mcfm_pkg::ST_CLIP_G: begin
                if (mul_done) begin
                    mul_a = prod_lo;
                    if (play_mono) begin
                        mul_cmd = '{start: 1'b1, rnd: mcfm_pkg::RND_29};
                        mul_b   = MB'(sum_mag);
                        n_sign  = sum_lr[SB];
                        n_state = mcfm_pkg::ST_CLIP_M;
                    end else begin
                        mul_cmd = '{start: 1'b1, rnd: mcfm_pkg::RND_28};
                        mul_b   = MB'(l_mag);
                        n_sign  = r_l[SB-1];
                        n_state = mcfm_pkg::ST_CLIP_L;
                    end
                end
            end
            mcfm_pkg::ST_CLIP_L: begin
                if (mul_done) begin
                    mul_cmd = '{start: 1'b1, rnd: mcfm_pkg::RND_28};
                    mul_a   = r_g;
                    mul_b   = MB'(r_mag);
                    n_sign  = r_r[SB-1];
                    n_state = mcfm_pkg::ST_CLIP_R;
                end
            end
            mcfm_pkg::ST_CLIP_R, mcfm_pkg::ST_CLIP_M: begin
                if (mul_done) begin
                    n_state = mcfm_pkg::ST_IDLE;
                end
            end
            mcfm_pkg::ST_FE_L: begin
                if (mul_done) begin
                    mul_cmd = '{start: 1'b1, rnd: mcfm_pkg::RND_12};
                    mul_a   = acc_r_mag;
                    mul_b   = MB'(r_master_gain);
                    n_sign  = r_acc_r[ACW-1];
                    n_state = mcfm_pkg::ST_FE_R;
                end
            end
            mcfm_pkg::ST_FE_R: begin
                if (mul_done) begin
                    n_state = mcfm_pkg::ST_FE_OUT;
                end
            end
            mcfm_pkg::ST_FE_OUT: begin
                if (out_free) begin
                    n_state = mcfm_pkg::ST_IDLE;
                end
            end
            default: n_state = mcfm_pkg::ST_IDLE;
        endcase
    end

    // Word capture and per-operation scratch
    always_ff @(posedge i_clk) begin
        r_sign <= n_sign;
        if (r_state == mcfm_pkg::ST_IDLE && i_in_valid) begin
            r_kind <= mcfm_pkg::t_kind'(i_req_type);
            r_l    <= i_sample_left;
            r_r    <= i_sample_right;
            r_cg   <= i_clip_gain;
        end
        if (r_state == mcfm_pkg::ST_CLIP_G && mul_done) begin
            r_g <= prod_lo;
        end
        if (r_state == mcfm_pkg::ST_FE_L && mul_done) begin
            r_ol_mag <= prod[OM-1:0];
            r_ol_neg <= r_sign;
        end
        if (r_state == mcfm_pkg::ST_FE_R && mul_done) begin
            r_or_mag <= play_mono ? r_ol_mag : prod[OM-1:0];
            r_or_neg <= play_mono ? r_ol_neg : r_sign;
        end
    end

    // Accumulators and peak holds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_l       <= '0;
            r_acc_r       <= '0;
            r_mic_peak    <= '0;
            r_master_peak <= '0;
        end else begin
            unique case (r_state)
                mcfm_pkg::ST_DECODE: begin
                    if (r_kind == mcfm_pkg::KIND_PEAK_CLR) begin
                        r_mic_peak    <= '0;
                        r_master_peak <= '0;
                    end
                end
                mcfm_pkg::ST_MIC_GAIN: begin
                    if (mul_done && mic_a > r_mic_peak) begin
                        r_mic_peak <= mic_a;
                    end
                end
                mcfm_pkg::ST_MIC_MIX, mcfm_pkg::ST_CLIP_M: begin
                    if (mul_done) begin
                        r_acc_l <= acc_l_add;
                        r_acc_r <= acc_r_add;
                    end
                end
                mcfm_pkg::ST_CLIP_L: begin
                    if (mul_done) begin
                        r_acc_l <= acc_l_add;
                    end
                end
                mcfm_pkg::ST_CLIP_R: begin
                    if (mul_done) begin
                        r_acc_r <= acc_r_add;
                    end
                end
                mcfm_pkg::ST_FE_OUT: begin
                    if (out_free) begin
                        r_acc_l       <= '0;
                        r_acc_r       <= '0;
                        r_master_peak <= pk_new;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == mcfm_pkg::ST_FE_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mcfm_pkg::ST_FE_OUT && out_free) begin
            r_out_l   <= limit(r_ol_mag, r_ol_neg);
            r_out_r   <= limit(r_or_mag, r_or_neg);
            r_out_mpk <= r_mic_peak;
            r_out_spk <= pk_new;
        end
    end

    assign o_in_ready    = (r_state == mcfm_pkg::ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_left    = r_out_l;
    assign o_out_right   = r_out_r;
    assign o_mic_peak    = r_out_mpk;
    assign o_master_peak = r_out_spk;

endmodule

FILE: hw/rtl/mcfm_checker.sv
// Port-level checks of the mixer top level, bound to every instance.
module mcfm_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_ready,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic signed [SAMPLE_BITS-1:0]         o_out_left,
    input logic signed [SAMPLE_BITS-1:0]         o_out_right,
    input logic [mcfm_pkg::MIC_PK_BITS-1:0]      o_mic_peak,
    input logic [mcfm_pkg::MST_PK_BITS-1:0]      o_master_peak
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // One word at a time: the decode cycle follows every accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again directly after an accept");

    // A frame is emitted only from the output load step, never while idle
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("output word appeared while input side was idle");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_left)
            && $stable(o_out_right) && $stable(o_mic_peak) && $stable(o_master_peak))
        else $error("stalled output word changed");

endmodule

bind mic_clip_frame_mixer_unit mcfm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mcfm_checker (.*);
